FILE: rtl/seam_energy_map_assert.svh
// assertion macros shared by the seam energy map rtl
`ifndef SEAM_ENERGY_MAP_ASSERT_SVH
`define SEAM_ENERGY_MAP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SEM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SEM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sem_pkg.sv
// shared types and constants of the seam energy map
package sem_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam int LUMA_W   = 18;
  localparam int GRAD_W   = 21;
  localparam int ENERGY_W = 31;
  localparam int COORD_W  = 10;
  localparam int PIXEL_W  = 32;
  localparam int MAG_W    = 20;
  localparam int SOB_W    = 23;
  localparam int RAD_W    = 42;

  localparam logic [9:0] LUMA_R = 10'd299;
  localparam logic [9:0] LUMA_G = 10'd587;
  localparam logic [9:0] LUMA_B = 10'd114;

  localparam logic [ENERGY_W-1:0] ENERGY_SAT = {ENERGY_W{1'b1}};

endpackage

FILE: rtl/sem_isqrt.sv
// iterative integer square root, two radicand bits per cycle
module sem_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sem_pkg::RAD_W-1:0]  radicand,
  output logic                       done,
  output logic [sem_pkg::GRAD_W-1:0] root
);
  import sem_pkg::*;

  localparam int REM_W = GRAD_W + 3;
  localparam int CNT_W = $clog2(GRAD_W + 1);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [GRAD_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(GRAD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[GRAD_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[GRAD_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: rtl/seam_energy_map.sv
// top level of the seam energy map: sobel gradient and cumulative seam energy
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | op, pixel (request)
//  out_    | output    | out_valid/stall  | col, row, gradient, energy, last
//  cfg_    | input     | cfg_valid/ready  | index, data
//
// a pixel request whose result is still a row and a column away ends after
// the read state; one that produces a result also passes the sobel, squaring,
// root (21-step square root unit) and output states. reset (rst_n low,
// synchronous) clears the control state and the window; the line memories are
// not cleared. a finished result sits in the output register while the next
// request is taken; only a result that is ready while the register is still
// stalled holds the sequencer. register writes are taken only while idle.
`include "seam_energy_map_assert.svh"

module seam_energy_map #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic [sem_pkg::PIXEL_W-1:0]     in_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sem_pkg::COORD_W-1:0]     out_col,
  output logic [sem_pkg::COORD_W-1:0]     out_row,
  output logic [sem_pkg::GRAD_W-1:0]      out_gradient,
  output logic [sem_pkg::ENERGY_W-1:0]    out_energy,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sem_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import sem_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HA = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SOB, S_SQX, S_SQY, S_ROOT, S_OUT
  } state_t;

  state_t state_r;

  // frame geometry
  logic [WW-1:0] w_r;
  logic [HW-1:0] h_r;

  // input side position (column and row of the incoming request)
  logic [AW-1:0] xi_r;
  logic [YW-1:0] yi_r;
  // output side position (pixel the next result describes)
  logic [AW-1:0] cx_r;
  logic [HA-1:0] cy_r;

  logic [LUMA_W-1:0]   v_r;
  logic [LUMA_W-1:0]   win_r [3][3];
  logic [ENERGY_W-1:0] above_left_r;
  logic [ENERGY_W-1:0] e_mid_r;
  logic [ENERGY_W-1:0] e_right_r;
  logic [MAG_W-1:0]    gxa_r;
  logic [MAG_W-1:0]    gya_r;
  logic [2*MAG_W-1:0]  sqx_r;
  logic [2*MAG_W-1:0]  sqy;

  logic                out_valid_r;
  logic [COORD_W-1:0]  out_col_r;
  logic [COORD_W-1:0]  out_row_r;
  logic [GRAD_W-1:0]   out_grad_r;
  logic [ENERGY_W-1:0] out_energy_r;
  logic                out_last_r;

  // line memories: luma keeps {older row, newer row}
  logic [2*LUMA_W-1:0] luma_mem [MAX_WIDTH];
  logic [2*LUMA_W-1:0] luma_rd_r;
  logic [ENERGY_W-1:0] energy_mem [MAX_WIDTH];
  logic [ENERGY_W-1:0] energy_rd_r;
  logic [AW-1:0]       energy_raddr;

  logic                in_fire;
  logic                cfg_fire;
  logic                out_free;
  logic                out_load;
  logic                no_result;
  logic                in_frame;
  logic                has_t, has_b, has_l, has_r;
  logic                is_last;
  logic                xi_wrap, cx_wrap;
  logic [LUMA_W-1:0]   luma;
  logic [LUMA_W-1:0]   top_l, mid_l;
  logic signed [SOB_W-1:0] gx, gy;
  logic [RAD_W-1:0]    radicand;
  logic                sq_start, sq_done;
  logic [GRAD_W-1:0]   sq_root;
  logic [ENERGY_W-1:0] m_min;
  logic [ENERGY_W:0]   e_sum;
  logic [ENERGY_W-1:0] e_val;
  logic [WW-1:0]       w_clamp;
  logic [HW-1:0]       h_clamp;

  assign in_fire   = in_valid && !in_stall;
  assign cfg_fire  = cfg_valid && cfg_ready;
  // registers only change while no request is in flight
  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_OUT) && out_free;

  assign in_frame  = (yi_r < YW'(h_r));
  assign no_result = (yi_r == '0) || ((yi_r == YW'(1)) && (xi_r == '0));
  assign xi_wrap   = (WW'(xi_r) + WW'(1)) == w_r;
  assign cx_wrap   = (WW'(cx_r) + WW'(1)) == w_r;
  assign has_t     = (cy_r != '0);
  assign has_b     = (HW'(cy_r) + HW'(1)) < h_r;
  assign has_l     = (cx_r != '0);
  assign has_r     = !cx_wrap;
  assign is_last   = cx_wrap && ((HW'(cy_r) + HW'(1)) == h_r);

  assign luma = LUMA_W'(LUMA_R * in_pixel[7:0])
              + LUMA_W'(LUMA_G * in_pixel[15:8])
              + LUMA_W'(LUMA_B * in_pixel[23:16]);

  assign top_l = luma_rd_r[2*LUMA_W-1:LUMA_W];
  assign mid_l = luma_rd_r[LUMA_W-1:0];

  // clamp register writes into the supported range
  always_comb begin
    if (cfg_data == '0) begin
      w_clamp = WW'(1);
      h_clamp = HW'(1);
    end else begin
      w_clamp = (32'(cfg_data) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(cfg_data);
      h_clamp = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
    end
  end

  // sobel over the window, out-of-frame neighbours dropped
  always_comb begin
    logic rok [3];
    logic cok [3];
    logic signed [SOB_W-1:0] a, b;
    rok[0] = has_t;
    rok[1] = 1'b1;
    rok[2] = has_b;
    cok[0] = has_l;
    cok[1] = 1'b1;
    cok[2] = has_r;
    gx = '0;
    gy = '0;
    for (int k = 0; k < 3; k++) begin
      a = (rok[k] && cok[0]) ? SOB_W'(win_r[k][0]) : '0;
      b = (rok[k] && cok[2]) ? SOB_W'(win_r[k][2]) : '0;
      gx = gx + ((k == 1) ? ((a - b) <<< 1) : (a - b));
      a = (rok[0] && cok[k]) ? SOB_W'(win_r[0][k]) : '0;
      b = (rok[2] && cok[k]) ? SOB_W'(win_r[2][k]) : '0;
      gy = gy + ((k == 1) ? ((a - b) <<< 1) : (a - b));
    end
  end

  assign sqy      = gya_r * gya_r;
  assign radicand = RAD_W'(sqx_r) + RAD_W'(sqy);
  assign sq_start = (state_r == S_SQY);

  sem_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  // smallest in-frame energy above, then saturating add; the top row takes the gradient alone
  always_comb begin
    m_min = e_mid_r;
    if (has_l && (above_left_r < m_min)) m_min = above_left_r;
    if (has_r && (e_right_r < m_min)) m_min = e_right_r;
    e_sum = (ENERGY_W+1)'(m_min) + (ENERGY_W+1)'(sq_root);
    if (!has_t) begin
      e_val = ENERGY_W'(sq_root);
    end else if (e_sum > (ENERGY_W+1)'(ENERGY_SAT)) begin
      e_val = ENERGY_SAT;
    end else begin
      e_val = e_sum[ENERGY_W-1:0];
    end
  end

  assign energy_raddr = (state_r == S_RD) ? AW'(cx_r + 1'b1) : cx_r;

  // memories
  always_ff @(posedge clk) begin
    luma_rd_r   <= luma_mem[xi_r];
    energy_rd_r <= energy_mem[energy_raddr];
    if (state_r == S_RD) begin
      luma_mem[xi_r] <= {mid_l, v_r};
    end
    if (out_load) begin
      energy_mem[cx_r] <= e_val;
    end
  end

  // sequencer, positions, window and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      w_r          <= WW'(MAX_WIDTH);
      h_r          <= HW'(MAX_HEIGHT);
      xi_r         <= '0;
      yi_r         <= '0;
      cx_r         <= '0;
      cy_r         <= '0;
      above_left_r <= '0;
      out_valid_r  <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      if (out_valid_r && !out_stall && !out_load) out_valid_r <= 1'b0;

      if (cfg_fire && ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT))) begin
        if (cfg_index == REG_IMAGE_WIDTH) w_r <= w_clamp;
        else h_r <= h_clamp;
        // frame restarts
        xi_r         <= '0;
        yi_r         <= '0;
        cx_r         <= '0;
        cy_r         <= '0;
        above_left_r <= '0;
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            win_r[r][c] <= '0;
          end
        end
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            v_r     <= (!in_op && in_frame) ? luma : '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          e_mid_r <= energy_rd_r;
          for (int r = 0; r < 3; r++) begin
            win_r[r][0] <= win_r[r][1];
            win_r[r][1] <= win_r[r][2];
          end
          win_r[0][2] <= top_l;
          win_r[1][2] <= mid_l;
          win_r[2][2] <= v_r;
          if (no_result) begin
            xi_r    <= xi_wrap ? '0 : xi_r + 1'b1;
            yi_r    <= xi_wrap ? yi_r + 1'b1 : yi_r;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SOB;
          end
        end
        S_SOB: begin
          e_right_r <= energy_rd_r;
          gxa_r     <= MAG_W'(gx[SOB_W-1] ? -gx : gx);
          gya_r     <= MAG_W'(gy[SOB_W-1] ? -gy : gy);
          state_r   <= S_SQX;
        end
        S_SQX: begin
          sqx_r   <= gxa_r * gxa_r;
          state_r <= S_SQY;
        end
        S_SQY: begin
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_col_r    <= COORD_W'(cx_r);
            out_row_r    <= COORD_W'(cy_r);
            out_grad_r   <= sq_root;
            out_energy_r <= e_val;
            out_last_r   <= is_last;
            above_left_r <= e_mid_r;
            if (is_last) begin
              xi_r <= '0;
              yi_r <= '0;
              cx_r <= '0;
              cy_r <= '0;
            end else begin
              xi_r <= xi_wrap ? '0 : xi_r + 1'b1;
              yi_r <= xi_wrap ? yi_r + 1'b1 : yi_r;
              cx_r <= cx_wrap ? '0 : cx_r + 1'b1;
              cy_r <= cx_wrap ? cy_r + 1'b1 : cy_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_col      = out_col_r;
  assign out_row      = out_row_r;
  assign out_gradient = out_grad_r;
  assign out_energy   = out_energy_r;
  assign out_last     = out_last_r;

  // positions stay inside the row
  `SEM_ASSERT_IMP(a_pos_in_row, 1'b1, (WW'(cx_r) < w_r) && (WW'(xi_r) < w_r), "position past row end")
  // the root unit only finishes while the sequencer waits for it
  `SEM_ASSERT_IMP(a_root_wait, sq_done, state_r == S_ROOT, "square root done out of turn")
  // the last pixel of a frame restarts both positions
  `SEM_ASSERT_NXT(a_frame_wrap, (state_r == S_OUT) && out_free && is_last && !cfg_fire, (cx_r == '0) && (cy_r == '0) && (yi_r == '0), "frame did not restart")

endmodule

FILE: tb/sv/seam_energy_map_test.sv
// seam_energy_map_test: random and directed check of the sobel seam energy map
`timescale 1ns / 100ps

module seam_energy_map_test;
  import sem_pkg::*;

  localparam int MAX_DIM     = 1024;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 60;  // settling wait before each register write and at the end

  typedef struct packed {
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [GRAD_W-1:0]   gradient;
    logic [ENERGY_W-1:0] energy;
    logic                last;
  } seam_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_op;
  logic [PIXEL_W-1:0]   in_pixel;
  logic                 out_valid;
  logic                 out_stall;
  logic [COORD_W-1:0]   out_col;
  logic [COORD_W-1:0]   out_row;
  logic [GRAD_W-1:0]    out_gradient;
  logic [ENERGY_W-1:0]  out_energy;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  seam_energy_map dut (.*);

  // predictor state: luminance lines, sobel window, energy row, frame position
  logic [LUMA_W-1:0]   luma_rows [2][MAX_DIM];
  logic [LUMA_W-1:0]   win [3][3];
  logic [ENERGY_W-1:0] energy_row [MAX_DIM];
  int unsigned         frame_pos;
  logic [ENERGY_W-1:0] energy_upleft;
  int unsigned         img_w;
  int unsigned         img_h;

  seam_result_t expected_q[$];
  int           fail_count;
  int           gap_pct;       // chance in 100 that the sender idles after a request
  int           stall_pct;     // chance in 100 that the receiver stalls in a cycle
  int           holdoff;       // cycles of forced receiver stall still to go
  int           phase_items;
  int unsigned  cycle_count;

  // clock and watchdog
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("seam_energy_map_test failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(input logic [CFG_DAT_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic logic [31:0] floor_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned bit_val;
    res = 0;
    bit_val = 64'd1 << 62;
    while (bit_val > n) bit_val >>= 2;
    while (bit_val != 0) begin
      if (n >= res + bit_val) begin
        n -= res + bit_val;
        res = (res >> 1) + bit_val;
      end else begin
        res >>= 1;
      end
      bit_val >>= 2;
    end
    return res[31:0];
  endfunction

  // a register write restarts the frame and clears the window
  function automatic void restart_frame();
    frame_pos = 0;
    energy_upleft = '0;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) win[r][k] = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] val);
    if (idx == REG_IMAGE_WIDTH) begin
      img_w = clamp_dim(val);
      restart_frame();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      img_h = clamp_dim(val);
      restart_frame();
    end
  endfunction

  // advance the energy map by one request; returns 1 when a pixel result is due
  function automatic bit predict_energy(input logic op, input logic [31:0] px,
                                        output seam_result_t res);
    int unsigned       frame_len, xi, c, cy, cx;
    logic [LUMA_W-1:0] v, top, mid;
    bit                has_t, has_b, has_l, has_r;
    longint            gx, gy, l;
    longint            wt [3];
    logic [31:0]       g;
    longint unsigned   s;
    logic [ENERGY_W-1:0] m, e;
    wt = '{1, 2, 1};
    frame_len = img_w * img_h;
    xi = frame_pos % img_w;
    v = (op == 1'b0 && frame_pos < frame_len) ?
        LUMA_W'(299 * px[7:0] + 587 * px[15:8] + 114 * px[23:16]) : '0;
    top = luma_rows[0][xi];
    mid = luma_rows[1][xi];
    luma_rows[0][xi] = mid;
    luma_rows[1][xi] = v;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = v;
    res = '0;
    if (frame_pos < img_w + 1) begin
      frame_pos++;
      return 0;
    end
    c = frame_pos - img_w - 1;
    cy = c / img_w;
    cx = c % img_w;
    has_t = cy > 0;
    has_b = cy + 1 < img_h;
    has_l = cx > 0;
    has_r = cx + 1 < img_w;
    gx = 0;
    gy = 0;
    // absent neighbours outside the frame simply drop out of both kernels
    for (int dy = 0; dy < 3; dy++) begin
      if ((dy == 0 && !has_t) || (dy == 2 && !has_b)) continue;
      for (int dx = 0; dx < 3; dx++) begin
        if ((dx == 0 && !has_l) || (dx == 2 && !has_r)) continue;
        l = win[dy][dx];
        gx += l * wt[dy] * (1 - dx);
        gy += l * wt[dx] * (1 - dy);
      end
    end
    g = floor_sqrt(longint'(gx * gx) + longint'(gy * gy));
    if (!has_t) begin
      e = g[ENERGY_W-1:0];
    end else begin
      m = energy_row[cx];
      if (has_l && energy_upleft < m) m = energy_upleft;
      if (has_r && energy_row[cx + 1] < m) m = energy_row[cx + 1];
      s = longint'(m) + g;
      e = (s > longint'(ENERGY_SAT)) ? ENERGY_SAT : s[ENERGY_W-1:0];
    end
    energy_upleft = energy_row[cx];
    energy_row[cx] = e;
    res.col = cx[COORD_W-1:0];
    res.row = cy[COORD_W-1:0];
    res.gradient = g[GRAD_W-1:0];
    res.energy = e;
    res.last = (c == frame_len - 1);
    frame_pos = res.last ? 0 : frame_pos + 1;
    return 1;
  endfunction

  // receiver: random stalls, or a forced hold-off counted here
  always @(posedge clk) begin
    if (holdoff > 0) begin
      out_stall <= 1'b1;
      holdoff <= holdoff - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    seam_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result col %0d row %0d", out_col, out_row);
        fail_count++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_col !== exp_res.col) begin
          $error("col expected %0d got %0d", exp_res.col, out_col);
          fail_count++;
        end
        if (out_row !== exp_res.row) begin
          $error("row expected %0d got %0d", exp_res.row, out_row);
          fail_count++;
        end
        if (out_gradient !== exp_res.gradient) begin
          $error("gradient expected %0d got %0d", exp_res.gradient, out_gradient);
          fail_count++;
        end
        if (out_energy !== exp_res.energy) begin
          $error("energy expected %0d got %0d", exp_res.energy, out_energy);
          fail_count++;
        end
        if (out_last !== exp_res.last) begin
          $error("last expected %0d got %0d", exp_res.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // one request on the input channel; predicts at acceptance
  task automatic push_request(input logic op, input logic [31:0] px);
    seam_result_t res;
    in_valid <= 1'b1;
    in_op    <= op;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_energy(op, px, res)) expected_q.push_back(res);
    phase_items++;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic stop_requests();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // register write only once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  // configure, then stream a frame of random pixels and its drain;
  // a positive cut_at stops the frame early to leave it broken
  task automatic run_frame(input logic [CFG_DAT_W-1:0] w_raw,
                           input logic [CFG_DAT_W-1:0] h_raw,
                           input int flush_pct, input int cut_at);
    int unsigned total, body;
    write_reg(REG_IMAGE_WIDTH, w_raw);
    write_reg(REG_IMAGE_HEIGHT, h_raw);
    body  = img_w * img_h;
    total = body + img_w + 1;
    for (int unsigned i = 0; i < total; i++) begin
      if (cut_at > 0 && i == cut_at) break;
      if (i < body)
        push_request($urandom_range(99) < flush_pct, $urandom);
      else
        push_request(1'($urandom_range(1)), $urandom);  // past the end: flush or ignored pixel
    end
    stop_requests();
  endtask

  task automatic test_directed_pixels();
    logic [31:0] pix [9];
    pix = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00FF, 32'h0000_FF00,
            32'h00FF_0000, 32'hFF00_0000, 32'h00FF_FFFF, 32'h0000_0000,
            32'h1234_5678};
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    write_reg(REG_IMAGE_HEIGHT, 11'd3);
    for (int i = 0; i < 9; i++)
      push_request(i == 7, pix[i]);           // a flush inside the frame at pixel 7
    push_request(1'b0, 32'hFFFF_FFFF);         // pixel past the end, data ignored
    push_request(1'b1, 32'h0);
    push_request(1'b0, 32'h00FF_FFFF);
    push_request(1'b1, 32'hFFFF_FFFF);
    stop_requests();
    // single pixel frame, from register values of zero
    write_reg(REG_IMAGE_WIDTH, 11'd0);
    write_reg(REG_IMAGE_HEIGHT, 11'd0);
    push_request(1'b0, 32'h00FF_FFFF);
    push_request(1'b1, 32'h0);
    push_request(1'b1, 32'h0);
    stop_requests();
    // 2x2 checkerboard of full white and black
    write_reg(REG_IMAGE_WIDTH, 11'd2);
    write_reg(REG_IMAGE_HEIGHT, 11'd2);
    push_request(1'b0, 32'h00FF_FFFF);
    push_request(1'b0, 32'h0);
    push_request(1'b0, 32'h0);
    push_request(1'b0, 32'h00FF_FFFF);
    repeat (3) push_request(1'b1, 32'h0);
    stop_requests();
  endtask

  // unused register indexes are ignored and must not restart the frame
  task automatic test_unused_index();
    write_reg(REG_IMAGE_WIDTH, 11'd4);
    write_reg(REG_IMAGE_HEIGHT, 11'd3);
    repeat (6) push_request(1'b0, $urandom);
    stop_requests();
    write_reg(2'd2, 11'h7FF);
    write_reg(2'd3, 11'h000);
    repeat (11) push_request(1'b0, $urandom);
    stop_requests();
  endtask

  task automatic test_extreme_sizes();
    gap_pct = 0;
    stall_pct = 0;
    run_frame(11'h7FF, 11'd1, 3, 120);  // widest row, clamped to the maximum, cut short
    run_frame(11'd1, 11'h7FF, 3, 60);   // tallest column, clamped to the maximum, cut short
    run_frame(11'd30, 11'd3, 0, 0);
  endtask

  task automatic test_random_phase(input int gp, input int sp);
    int w, h;
    gap_pct = gp;
    stall_pct = sp;
    phase_items = 0;
    while (phase_items < 140) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      // one frame in ten is cut short to leave a broken sequence behind
      run_frame(CFG_DAT_W'(w), CFG_DAT_W'(h), 5,
                ($urandom_range(9) == 0) ? $urandom_range(1, w * h) : 0);
    end
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    write_reg(REG_IMAGE_WIDTH, 11'd5);
    write_reg(REG_IMAGE_HEIGHT, 11'd4);
    holdoff = 400;                       // receiver blocked while the sender keeps offering requests
    repeat (14) push_request(1'b0, $urandom);
    stop_requests();
    wait_drained();                      // sender pauses until every result is back
    repeat (12) push_request(1'b0, $urandom);
    stop_requests();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = 1'b0;
    in_pixel = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_stall = 1'b0;
    fail_count = 0;
    gap_pct = 0;
    stall_pct = 0;
    holdoff = 0;
    phase_items = 0;
    cycle_count = 0;
    img_w = MAX_DIM;
    img_h = MAX_DIM;
    for (int i = 0; i < MAX_DIM; i++) begin
      luma_rows[0][i] = '0;
      luma_rows[1][i] = '0;
      energy_row[i] = '0;
    end
    restart_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_pixels();
    test_unused_index();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(58, 0);
    test_random_phase(0, 58);
    test_random_phase(13, 13);
    test_extreme_sizes();

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("seam_energy_map_test passed");
    end else begin
      $display("seam_energy_map_test failed");
    end
    $finish;
  end

endmodule
